FILE: sv/wsp_pkg.sv
// Shared types, sizes, constants and the sine table for the world to screen projection.
package wsp_pkg;

  localparam int COORD_BITS   = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);

  localparam int TRIG_W     = 17;
  localparam int TPROD_W    = 2 * TRIG_W;
  localparam int Q15_SHIFT  = 15;
  localparam int ROUND_Q15  = 16384;
  localparam int TERM_SHIFT = 7;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = DIFF_W + TRIG_W;
  localparam int TERM_W  = PROD_W - TERM_SHIFT;
  localparam int SUM_W   = TERM_W + 2;
  localparam int MAG_W   = SUM_W;
  localparam int DIM_W   = 14;
  localparam int SCALE_W = DIM_W + 3;
  localparam int NUM_W   = MAG_W + SCALE_W + 1;
  localparam int Q_BITS  = 25;
  localparam int Q_IDX_W = $clog2(Q_BITS);
  localparam int DIV_W   = SUM_W + Q_BITS + 1;
  localparam int OSUM_W  = Q_BITS + 3;
  localparam int OUT_W   = 24;

  localparam int FWD_MIN = 655;
  localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN = -(2 ** (OUT_W - 1));

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;

  localparam int SCREEN_W_RST = 1920;
  localparam int SCREEN_H_RST = 1080;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SERIES_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEWER_X,
    REG_VIEWER_Y,
    REG_VIEWER_Z,
    REG_VIEW_PITCH,
    REG_VIEW_YAW,
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sp;
    logic signed [TRIG_W-1:0] cp;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] cysp;
    logic signed [TRIG_W-1:0] sysp;
  } trig_t;

  typedef struct packed {
    logic             vis;
    logic             neg_s;
    logic             neg_u;
    logic [NUM_W-1:0] n_s;
    logic [NUM_W-1:0] n_u;
    logic [SUM_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic              vis;
    logic              neg_s;
    logic              neg_u;
    logic              sat_s;
    logic              sat_u;
    logic [Q_BITS-1:0] mag_s;
    logic [Q_BITS-1:0] mag_u;
  } div_out_t;

  typedef logic signed [TRIG_W-1:0] sine_tab_t [SINE_ENTRIES];

  function automatic logic signed [TRIG_W-1:0] sin_quadrant(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int i = 1; i <= 7; i++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[i-1];
      if ((i & 1) != 0) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (sum + 16384) >>> 15;
    if (v > 32768) v = 32768;
    return TRIG_W'(v);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t                tab;
    longint unsigned          t;
    longint unsigned          q;
    longint unsigned          r;
    logic signed [TRIG_W-1:0] s;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      t = 4 * longint'(k);
      q = t / SINE_ENTRIES;
      r = t % SINE_ENTRIES;
      if ((q & 1) != 0) r = SINE_ENTRIES - r;
      s = sin_quadrant(HALF_PI_Q30 * r / SINE_ENTRIES);
      tab[k] = (q >= 2) ? -s : s;
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  function automatic logic signed [TERM_W-1:0] mul_term(logic signed [DIFF_W-1:0] d,
                                                        logic signed [TRIG_W-1:0] t);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(d) * PROD_W'(t);
    return p[PROD_W-1:TERM_SHIFT];
  endfunction

  function automatic logic signed [TRIG_W-1:0] trig_mul(logic signed [TRIG_W-1:0] a,
                                                        logic signed [TRIG_W-1:0] b);
    logic signed [TPROD_W-1:0] p;
    p = TPROD_W'(a) * TPROD_W'(b) + TPROD_W'(ROUND_Q15);
    return p[Q15_SHIFT+TRIG_W-1:Q15_SHIFT];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(logic signed [OSUM_W-1:0] v);
    if (v > OSUM_W'(OUT_MAX)) return OUT_W'(OUT_MAX);
    if (v < OSUM_W'(OUT_MIN)) return OUT_W'(OUT_MIN);
    return v[OUT_W-1:0];
  endfunction

endpackage

FILE: sv/wsp_sine_rom.sv
// Dual read port sine table with registered read data.
module wsp_sine_rom (
  input  logic                                  clk,
  input  logic [wsp_pkg::SINE_IDX_W-1:0]        addr_a,
  input  logic [wsp_pkg::SINE_IDX_W-1:0]        addr_b,
  output logic signed [wsp_pkg::TRIG_W-1:0]     data_a,
  output logic signed [wsp_pkg::TRIG_W-1:0]     data_b
);
  import wsp_pkg::*;

  logic signed [TRIG_W-1:0] data_a_r;
  logic signed [TRIG_W-1:0] data_b_r;

  always_ff @(posedge clk) begin
    data_a_r <= SINE_TAB[addr_a];
    data_b_r <= SINE_TAB[addr_b];
  end

  assign data_a = data_a_r;
  assign data_b = data_b_r;

endmodule

FILE: sv/wsp_trig.sv
// Pitch and yaw sine/cosine lookup plus the rounded pitch cross terms.
module wsp_trig (
  input  logic                             clk,
  input  logic [wsp_pkg::ANGLE_BITS-1:0]   pitch,
  input  logic [wsp_pkg::ANGLE_BITS-1:0]   yaw,
  output wsp_pkg::trig_t                   trig
);
  import wsp_pkg::*;

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic [ANGLE_BITS-1:0]    pitch_c;
  logic [ANGLE_BITS-1:0]    yaw_c;
  logic signed [TRIG_W-1:0] sp;
  logic signed [TRIG_W-1:0] cp;
  logic signed [TRIG_W-1:0] sy;
  logic signed [TRIG_W-1:0] cy;
  logic signed [TRIG_W-1:0] cysp_r;
  logic signed [TRIG_W-1:0] sysp_r;

  assign pitch_c = pitch + QUARTER;
  assign yaw_c   = yaw + QUARTER;

  wsp_sine_rom u_pitch_rom (
    .clk    (clk),
    .addr_a (pitch[ANGLE_BITS-1 -: SINE_IDX_W]),
    .addr_b (pitch_c[ANGLE_BITS-1 -: SINE_IDX_W]),
    .data_a (sp),
    .data_b (cp)
  );

  wsp_sine_rom u_yaw_rom (
    .clk    (clk),
    .addr_a (yaw[ANGLE_BITS-1 -: SINE_IDX_W]),
    .addr_b (yaw_c[ANGLE_BITS-1 -: SINE_IDX_W]),
    .data_a (sy),
    .data_b (cy)
  );

  always_ff @(posedge clk) begin
    cysp_r <= trig_mul(cy, sp);
    sysp_r <= trig_mul(sy, sp);
  end

  always_comb begin
    trig.sp   = sp;
    trig.cp   = cp;
    trig.sy   = sy;
    trig.cy   = cy;
    trig.cysp = cysp_r;
    trig.sysp = sysp_r;
  end

endmodule

FILE: sv/wsp_rotate.sv
// Offset, yaw/pitch rotation, visibility test and divider numerators, seven stages.
module wsp_rotate (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [wsp_pkg::COORD_BITS-1:0]  point_x,
  input  logic signed [wsp_pkg::COORD_BITS-1:0]  point_y,
  input  logic signed [wsp_pkg::COORD_BITS-1:0]  point_z,
  input  logic signed [wsp_pkg::COORD_BITS-1:0]  viewer_x,
  input  logic signed [wsp_pkg::COORD_BITS-1:0]  viewer_y,
  input  logic signed [wsp_pkg::COORD_BITS-1:0]  viewer_z,
  input  wsp_pkg::trig_t                         trig,
  input  logic [wsp_pkg::SCALE_W-1:0]            w8,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output wsp_pkg::div_in_t                       out_data
);
  import wsp_pkg::*;

  localparam int NSTG = 7;

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   rdy;

  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r;
  logic signed [DIFF_W-1:0]     dx_r, dy_r, dz_r;
  logic signed [TERM_W-1:0]     tfx_r, tfy_r, tsy_r, tsx_r, tuz_r;
  logic signed [DIFF_W-1:0]     dx3_r, dy3_r;
  logic signed [SUM_W-1:0]      fwd4_r, side4_r;
  logic signed [TERM_W-1:0]     tux_r, tuy_r, tuz4_r;
  logic signed [SUM_W-1:0]      fwd5_r, up5_r;
  logic [MAG_W-1:0]             mag_s5_r;
  logic                         neg_s5_r;
  logic signed [SUM_W-1:0]      fwd6_r;
  logic [MAG_W-1:0]             mag_s6_r, mag_u6_r;
  logic                         neg_s6_r, neg_u6_r, vis6_r;
  div_in_t                      out_r;

  logic [NSTG-1:0] v_nxt;

  assign rdy[NSTG] = out_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k]   = !v_r[k] || rdy[k+1];
    assign v_nxt[k] = rdy[k] ? ((k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1]) : v_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      px_r <= point_x;
      py_r <= point_y;
      pz_r <= point_z;
    end
    if (rdy[1]) begin
      dx_r <= DIFF_W'(px_r) - DIFF_W'(viewer_x);
      dy_r <= DIFF_W'(py_r) - DIFF_W'(viewer_y);
      dz_r <= DIFF_W'(pz_r) - DIFF_W'(viewer_z);
    end
    if (rdy[2]) begin
      tfx_r <= mul_term(dx_r, trig.cy);
      tfy_r <= mul_term(dy_r, trig.sy);
      tsy_r <= mul_term(dy_r, trig.cy);
      tsx_r <= mul_term(dx_r, trig.sy);
      tuz_r <= mul_term(dz_r, trig.cp);
      dx3_r <= dx_r;
      dy3_r <= dy_r;
    end
    if (rdy[3]) begin
      fwd4_r  <= SUM_W'(tfx_r) + SUM_W'(tfy_r);
      side4_r <= SUM_W'(tsy_r) - SUM_W'(tsx_r);
      tux_r   <= mul_term(dx3_r, trig.cysp);
      tuy_r   <= mul_term(dy3_r, trig.sysp);
      tuz4_r  <= tuz_r;
    end
    if (rdy[4]) begin
      fwd5_r   <= fwd4_r;
      up5_r    <= SUM_W'(tuz4_r) - SUM_W'(tux_r) - SUM_W'(tuy_r);
      neg_s5_r <= side4_r[SUM_W-1];
      mag_s5_r <= side4_r[SUM_W-1] ? MAG_W'(-side4_r) : MAG_W'(side4_r);
    end
    if (rdy[5]) begin
      fwd6_r   <= fwd5_r;
      vis6_r   <= fwd5_r > SUM_W'(FWD_MIN);
      mag_s6_r <= mag_s5_r;
      neg_s6_r <= neg_s5_r;
      neg_u6_r <= up5_r[SUM_W-1];
      mag_u6_r <= up5_r[SUM_W-1] ? MAG_W'(-up5_r) : MAG_W'(up5_r);
    end
    if (rdy[6]) begin
      out_r.vis   <= vis6_r;
      out_r.neg_s <= neg_s6_r;
      out_r.neg_u <= neg_u6_r;
      out_r.n_s   <= NUM_W'(mag_s6_r) * NUM_W'(w8) + NUM_W'(fwd6_r[SUM_W-1:1]);
      out_r.n_u   <= NUM_W'(mag_u6_r) * NUM_W'(w8) + NUM_W'(fwd6_r[SUM_W-1:1]);
      out_r.den   <= fwd6_r;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = out_r;

endmodule

FILE: sv/wsp_divide.sv
// Pipelined restoring divider, one quotient bit per stage for both screen axes.
module wsp_divide (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wsp_pkg::div_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wsp_pkg::div_out_t   out_data
);
  import wsp_pkg::*;

  localparam int NSTG = Q_BITS + 1;

  typedef struct packed {
    logic              vis;
    logic              neg_s;
    logic              neg_u;
    logic              ovf_s;
    logic              ovf_u;
    logic [DIV_W-1:0]  rem_s;
    logic [DIV_W-1:0]  rem_u;
    logic [Q_BITS-1:0] q_s;
    logic [Q_BITS-1:0] q_u;
    logic [SUM_W-1:0]  den;
  } div_stg_t;

  function automatic div_stg_t div_step(div_stg_t s, logic [Q_IDX_W-1:0] b);
    div_stg_t         o;
    logic [DIV_W-1:0] dsh;
    o   = s;
    dsh = DIV_W'(s.den) << b;
    if (s.rem_s >= dsh) begin
      o.rem_s  = s.rem_s - dsh;
      o.q_s[b] = 1'b1;
    end
    if (s.rem_u >= dsh) begin
      o.rem_u  = s.rem_u - dsh;
      o.q_u[b] = 1'b1;
    end
    return o;
  endfunction

  div_stg_t        stg_r   [NSTG];
  div_stg_t        stg_nxt [NSTG];
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   rdy;
  logic [DIV_W-1:0] den_top;

  assign den_top = DIV_W'(in_data.den) << Q_BITS;

  always_comb begin
    stg_nxt[0].vis   = in_data.vis;
    stg_nxt[0].neg_s = in_data.neg_s;
    stg_nxt[0].neg_u = in_data.neg_u;
    stg_nxt[0].rem_s = DIV_W'(in_data.n_s);
    stg_nxt[0].rem_u = DIV_W'(in_data.n_u);
    stg_nxt[0].ovf_s = DIV_W'(in_data.n_s) >= den_top;
    stg_nxt[0].ovf_u = DIV_W'(in_data.n_u) >= den_top;
    stg_nxt[0].q_s   = '0;
    stg_nxt[0].q_u   = '0;
    stg_nxt[0].den   = in_data.den;
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_step
    assign stg_nxt[k] = div_step(stg_r[k-1], Q_IDX_W'(Q_BITS - k));
  end

  assign rdy[NSTG] = out_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    assign rdy[k]   = !v_r[k] || rdy[k+1];
    assign v_nxt[k] = rdy[k] ? ((k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1]) : v_r[k];
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    out_data.vis   = stg_r[NSTG-1].vis;
    out_data.neg_s = stg_r[NSTG-1].neg_s;
    out_data.neg_u = stg_r[NSTG-1].neg_u;
    out_data.sat_s = stg_r[NSTG-1].ovf_s;
    out_data.sat_u = stg_r[NSTG-1].ovf_u;
    out_data.mag_s = stg_r[NSTG-1].q_s;
    out_data.mag_u = stg_r[NSTG-1].q_u;
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];

endmodule

FILE: sv/world_to_screen_projection.sv
// World to screen perspective projection top level: configuration, pipeline and output stage.
// Throughput: one point per cycle when not stalled; 7 rotate/scale, 26 divider, 1 output stages.
// The divider retires one quotient bit per stage and sets the pipeline depth.
// A stalled output holds; upstream bubbles still fill behind it.
// Synchronous active-low reset empties the pipeline and loads the register defaults.
module world_to_screen_projection (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [wsp_pkg::COORD_BITS-1:0]  in_point_x,
  input  logic signed [wsp_pkg::COORD_BITS-1:0]  in_point_y,
  input  logic signed [wsp_pkg::COORD_BITS-1:0]  in_point_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_visible,
  output logic signed [wsp_pkg::OUT_W-1:0]       out_screen_x,
  output logic signed [wsp_pkg::OUT_W-1:0]       out_screen_y,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import wsp_pkg::*;

  logic signed [COORD_BITS-1:0] vx_r, vy_r, vz_r;
  logic [ANGLE_BITS-1:0]        pitch_r, yaw_r;
  logic [DIM_W-1:0]             width_r, height_r;

  logic [SCALE_W-1:0] w8, h8;
  trig_t              trig;

  logic     rot_ready, rot_valid;
  div_in_t  rot_data;
  logic     div_ready, div_valid;
  div_out_t div_data;

  logic                      out_en;
  logic                      out_v_r;
  logic                      out_vis_r;
  logic signed [OUT_W-1:0]   out_sx_r, out_sy_r;
  logic signed [OUT_W-1:0]   sx_nxt, sy_nxt;
  logic signed [OSUM_W-1:0]  off_s, off_u, sx_full, sy_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r     <= '0;
      vy_r     <= '0;
      vz_r     <= '0;
      pitch_r  <= '0;
      yaw_r    <= '0;
      width_r  <= DIM_W'(SCREEN_W_RST);
      height_r <= DIM_W'(SCREEN_H_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VIEWER_X:      vx_r     <= cfg_data[COORD_BITS-1:0];
        REG_VIEWER_Y:      vy_r     <= cfg_data[COORD_BITS-1:0];
        REG_VIEWER_Z:      vz_r     <= cfg_data[COORD_BITS-1:0];
        REG_VIEW_PITCH:    pitch_r  <= cfg_data[ANGLE_BITS-1:0];
        REG_VIEW_YAW:      yaw_r    <= cfg_data[ANGLE_BITS-1:0];
        REG_SCREEN_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign w8 = {width_r, 3'b000};
  assign h8 = {height_r, 3'b000};

  wsp_trig u_trig (
    .clk   (clk),
    .pitch (pitch_r),
    .yaw   (yaw_r),
    .trig  (trig)
  );

  wsp_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (rot_ready),
    .point_x   (in_point_x),
    .point_y   (in_point_y),
    .point_z   (in_point_z),
    .viewer_x  (vx_r),
    .viewer_y  (vy_r),
    .viewer_z  (vz_r),
    .trig      (trig),
    .w8        (w8),
    .out_valid (rot_valid),
    .out_ready (div_ready),
    .out_data  (rot_data)
  );

  wsp_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rot_valid),
    .in_ready  (div_ready),
    .in_data   (rot_data),
    .out_valid (div_valid),
    .out_ready (out_en),
    .out_data  (div_data)
  );

  assign in_stall = !rot_ready;
  assign out_en   = !out_v_r || !out_stall;

  always_comb begin
    off_s   = signed'(OSUM_W'(div_data.mag_s));
    off_u   = signed'(OSUM_W'(div_data.mag_u));
    if (div_data.neg_s) off_s = -off_s;
    if (div_data.neg_u) off_u = -off_u;
    sx_full = signed'(OSUM_W'(w8)) + off_s;
    sy_full = signed'(OSUM_W'(h8)) - off_u;
    if (div_data.sat_s) begin
      sx_nxt = div_data.neg_s ? OUT_W'(OUT_MIN) : OUT_W'(OUT_MAX);
    end else begin
      sx_nxt = sat_out(sx_full);
    end
    if (div_data.sat_u) begin
      sy_nxt = div_data.neg_u ? OUT_W'(OUT_MAX) : OUT_W'(OUT_MIN);
    end else begin
      sy_nxt = sat_out(sy_full);
    end
    if (!div_data.vis) begin
      sx_nxt = '0;
      sy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_vis_r <= div_data.vis;
      out_sx_r  <= sx_nxt;
      out_sy_r  <= sy_nxt;
    end
  end

  assign out_valid    = out_v_r;
  assign out_visible  = out_vis_r;
  assign out_screen_x = out_sx_r;
  assign out_screen_y = out_sy_r;

  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output stage is empty");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_screen_x == '0 && out_screen_y == '0)
    else $error("hidden point with nonzero screen position");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

FILE: tb/tb_world_to_screen_projection.sv
// Self-checking testbench for world_to_screen_projection with a queue-fed driver and monitor.
module tb_world_to_screen_projection;
  timeunit 1ns;
  timeprecision 1ps;
  import wsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] UNUSED_IDX = 3'd7;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct {
    logic               vis;
    logic signed [23:0] sx;
    logic signed [23:0] sy;
  } proj_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic out_valid, out_stall, out_visible;
  logic signed [23:0] out_screen_x, out_screen_y;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  world_to_screen_projection u_top (.*);

  point_t point_q[$];
  proj_t  proj_q[$];
  int     sine_lut[1024];
  logic signed [31:0] vx, vy, vz;
  logic [15:0] pitch, yaw;
  logic [13:0] scr_w, scr_h;
  bit     hold, calm;
  int     mismatches, checked, visible_cnt, cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int quad_sine(longint unsigned x);
    longint unsigned x2, term;
    longint sum, v;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int i = 1; i <= 7; i++) begin
      term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (sum + 16384) >>> 15;
    if (v > 32768) v = 32768;
    return int'(v);
  endfunction

  function automatic longint angle_sine(logic [15:0] a);
    return longint'(sine_lut[a >> 6]);
  endfunction

  function automatic longint offset_px(longint num, longint den, longint unsigned w8);
    longint unsigned a, d, q, r, mag;
    if (w8 == 0) return 0;
    a = (num < 0) ? -num : num;
    d = den;
    q = a / d;
    if (q >= (64'd1 << 24)) mag = 64'd1 << 30;
    else begin
      r = a % d;
      while (d >= (64'd1 << 46)) begin
        r >>= 1;
        d >>= 1;
      end
      mag = q * w8 + (r * w8 + d / 2) / d;
    end
    return (num < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > OUT_MAX) return 24'sh7fffff;
    if (v < OUT_MIN) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic proj_t project(point_t p);
    proj_t e;
    longint sp, cp, sy, cy, cysp, sysp, dx, dy, dz, fwd, side, up;
    longint unsigned w8, h8;
    w8 = 64'(scr_w) * 8;
    h8 = 64'(scr_h) * 8;
    sp = angle_sine(pitch);
    cp = angle_sine(pitch + 16'd16384);
    sy = angle_sine(yaw);
    cy = angle_sine(yaw + 16'd16384);
    cysp = (cy * sp + 16384) >>> 15;
    sysp = (sy * sp + 16384) >>> 15;
    dx = longint'(p.x) - longint'(vx);
    dy = longint'(p.y) - longint'(vy);
    dz = longint'(p.z) - longint'(vz);
    fwd = ((dx * cy) >>> 7) + ((dy * sy) >>> 7);
    side = ((dy * cy) >>> 7) - ((dx * sy) >>> 7);
    up = ((dz * cp) >>> 7) - ((dx * cysp) >>> 7) - ((dy * sysp) >>> 7);
    if (fwd <= FWD_MIN) begin
      e.vis = 0;
      e.sx = 0;
      e.sy = 0;
    end else begin
      e.vis = 1;
      e.sx = clamp24(longint'(w8) + offset_px(side, fwd, w8));
      e.sy = clamp24(longint'(h8) - offset_px(up, fwd, w8));
    end
    return e;
  endfunction

  // driver
  always @(posedge clk) begin
    point_t p;
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        p.x = in_point_x;
        p.y = in_point_y;
        p.z = in_point_z;
        proj_q.push_back(project(p));
      end
      if (!in_valid || !in_stall) begin
        if (point_q.size() > 0 && !hold && (calm || $urandom_range(99) >= 10)) begin
          p = point_q.pop_front();
          in_point_x <= p.x;
          in_point_y <= p.y;
          in_point_z <= p.z;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    proj_t e;
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (proj_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result vis=%0b x=%0d y=%0d",
                                         out_visible, out_screen_x, out_screen_y);
        end else begin
          e = proj_q.pop_front();
          checked++;
          if (e.vis) visible_cnt++;
          if (out_visible !== e.vis || out_screen_x !== e.sx || out_screen_y !== e.sy) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp vis=%0b x=%0d y=%0d, got vis=%0b x=%0d y=%0d",
                       e.vis, e.sx, e.sy, out_visible, out_screen_x, out_screen_y);
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 10);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_world_to_screen_projection: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_VIEWER_X:      vx = val;
      REG_VIEWER_Y:      vy = val;
      REG_VIEWER_Z:      vz = val;
      REG_VIEW_PITCH:    pitch = val[15:0];
      REG_VIEW_YAW:      yaw = val[15:0];
      REG_SCREEN_WIDTH:  scr_w = val[13:0];
      REG_SCREEN_HEIGHT: scr_h = val[13:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (point_q.size() > 0 || proj_q.size() > 0 || in_valid) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_point(logic signed [31:0] x, y, z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    point_q.push_back(p);
  endtask

  function automatic logic signed [31:0] near_offset();
    logic signed [31:0] d;
    d = $urandom;
    return d >>> $urandom_range(31, 4);
  endfunction

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) add_point($urandom, $urandom, $urandom);
      else add_point(vx + near_offset(), vy + near_offset(), vz + near_offset());
    end
  endtask

  task automatic set_all(logic [31:0] x, y, z, logic [15:0] p, w_yaw, logic [13:0] w, h);
    write_reg(REG_VIEWER_X, x);
    write_reg(REG_VIEWER_Y, y);
    write_reg(REG_VIEWER_Z, z);
    write_reg(REG_VIEW_PITCH, 32'(p));
    write_reg(REG_VIEW_YAW, 32'(w_yaw));
    write_reg(REG_SCREEN_WIDTH, 32'(w));
    write_reg(REG_SCREEN_HEIGHT, 32'(h));
  endtask

  initial begin
    for (int k = 0; k < 1024; k++) begin
      int q, r, s;
      q = (4 * k) / 1024;
      r = (4 * k) % 1024;
      if (q % 2 == 1) r = 1024 - r;
      s = quad_sine(HALF_PI_Q30 * longint'(r) / 1024);
      sine_lut[k] = (q >= 2) ? -s : s;
    end
    vx = 0; vy = 0; vz = 0; pitch = 0; yaw = 0;
    scr_w = 14'(SCREEN_W_RST); scr_h = 14'(SCREEN_H_RST);
    hold = 1; calm = 0;
    rst_n = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; in_point_x = 0; in_point_y = 0; in_point_z = 0;
    out_stall = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // defaults: yaw 0 so forward depth is dx * 256
    add_point(0, 0, 0);
    add_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    add_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_point(2, 0, 0);
    add_point(3, 0, 0);
    add_point(3, 32'sh40000000, -32'sh40000000);
    add_point(3, -32'sh40000000, 32'sh40000000);
    add_point(32'sh7fffffff, 32'sh80000000, 0);
    add_point(1000 * 256, 500 * 256, -300 * 256);
    add_point(-1000 * 256, 5, 7);
    add_point(256, 256, 256);
    add_point(32'sh7fffffff, 0, 32'sh80000000);
    hold = 0;
    wait_idle();
    // pressure: sender held while 150 points are queued, then released
    hold = 1;
    add_random(150);
    repeat (10) @(posedge clk);
    hold = 0;
    wait_idle();

    set_all(32'h0000_1234, 32'hffff_8000, 32'h0001_0000, 16'd8000, 16'd16384, 14'd1, 14'd1);
    write_reg(UNUSED_IDX, 32'hffff_ffff);
    add_random(150);
    wait_idle();

    set_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'hffff, 16'hffff,
            14'd8192, 14'd8192);
    add_random(150);
    wait_idle();

    calm = 1;
    set_all($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 14'h3fff, 14'h3fff);
    add_random(150);
    wait_idle();
    calm = 0;

    set_all(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'($urandom), 16'($urandom),
            14'd0, 14'd0);
    add_random(100);
    wait_idle();

    set_all(0, 0, 0, 16'd0, 16'($urandom), 14'($urandom_range(16383)),
            14'($urandom_range(16383)));
    add_random(150);
    wait_idle();

    $display("covered %0d projected points (%0d visible) over 6 view settings", checked,
             visible_cnt);
    $display("settings included zero and maximum screen sizes and extreme viewer positions");
    if (mismatches == 0) begin
      $display("tb_world_to_screen_projection: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_world_to_screen_projection: FAIL");
    end
    $finish;
  end
endmodule
